[hw/rtl/rmis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_pkg
// Opcodes, stop codes and the control/status bundles shared by the
// register machine step controller, datapath and top level.
// ----------------------------------------------------------------------------
package rmis_pkg;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MV  = 4'd4;
    localparam logic [3:0] OP_ST  = 4'd5;
    localparam logic [3:0] OP_JMP = 4'd6;
    localparam logic [3:0] OP_JEQ = 4'd7;
    localparam logic [3:0] OP_JGT = 4'd8;
    localparam logic [3:0] OP_JLT = 4'd9;
    localparam logic [3:0] OP_W   = 4'd10;
    localparam logic [3:0] OP_R   = 4'd11;
    localparam logic [3:0] OP_STP = 4'd12;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_BADOP = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_PCOVF = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic ready;
        logic rd1;
        logic rd2;
        logic exec;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_valid;
        logic stopped;
        logic div_go;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/rmis_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_if
// Valid/ready channels of the register machine step: instruction in,
// step result out.
// ----------------------------------------------------------------------------
interface rmis_in_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  opcode;
    logic        [7:0]  operand_a;
    logic        [7:0]  operand_b;
    logic        [7:0]  operand_c;
    logic signed [31:0] read_value;

    modport source (
        output valid, opcode, operand_a, operand_b, operand_c, read_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, operand_a, operand_b, operand_c, read_value,
        output ready
    );
endinterface

interface rmis_out_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  next_pc;
    logic        [2:0]  status;
    logic               out_valid;
    logic signed [31:0] out_value;

    modport source (
        output valid, next_pc, status, out_valid, out_value,
        input  ready
    );
    modport sink (
        input  valid, next_pc, status, out_valid, out_value,
        output ready
    );
endinterface

[hw/rtl/register_machine_instruction_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_instruction_step
// Executes one register machine instruction per input transfer and returns
// the next pc, the status and any emitted word.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  i_in     | in  | valid / ready      | opcode, operand_a/b/c, read_value
//  o_out    | out | valid / ready      | next_pc, status, out_valid, out_value
//
//  An instruction passes from its transfer through two reads of one register
//  file port, then execute and commit. DIV waits in the bit-serial divider
//  before commit; a stopped machine goes straight from its transfer to commit.
//  After reset a clearing pass over max(REGS, min(DATA_DEPTH, 256)) addresses
//  zeroes the register file and data memory; i_in.ready stays low meanwhile.
//  A new instruction is taken while the previous result waits in the output
//  register; commit stalls only until that register is free.
// ----------------------------------------------------------------------------
module register_machine_instruction_step #(
    parameter int REGS        = 16,
    parameter int DATA_DEPTH  = 256,
    parameter int INSTR_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmis_in_if.sink     i_in,
    rmis_out_if.source  o_out
);
    import rmis_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rmis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rmis_dp #(
        .REGS        (REGS),
        .DATA_DEPTH  (DATA_DEPTH),
        .INSTR_DEPTH (INSTR_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

[hw/rtl/rmis_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_div
// Truncating signed 32-bit divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmis_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quo
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;

    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[31] ? (32'd0 - i_num) : i_num;
            r_den <= i_den[31] ? (32'd0 - i_den) : i_den;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            // keep the partial remainder when the trial subtract goes negative
            r_rem <= diff[32] ? shifted[31:0] : diff[31:0];
            r_quo <= {r_quo[30:0], ~diff[32]};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

[hw/rtl/rmis_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_ctrl
// Sequencer of the register machine step: clearing pass, operand reads,
// execute, divide wait and commit.
// ----------------------------------------------------------------------------
module rmis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rmis_pkg::t_sts i_sts,
    output rmis_pkg::t_cmd o_cmd
);
    import rmis_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD1   = 3'd2;
    localparam logic [2:0] S_RD2   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_DIVW  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_sts.in_valid) begin
                    // a stopped machine only reports its held state
                    n_state = i_sts.stopped ? S_FIN : S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.div_go ? S_DIVW : S_FIN;
            end
            S_DIVW: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/rmis_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_dp
// Datapath of the register machine step: register file and data memory,
// operand registers, multiplier, divider, pc and stop code, result register.
// ----------------------------------------------------------------------------
module rmis_dp #(
    parameter int REGS        = 16,
    parameter int DATA_DEPTH  = 256,
    parameter int INSTR_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rmis_pkg::t_cmd i_cmd,
    output rmis_pkg::t_sts o_sts,
    rmis_in_if.sink        i_in,
    rmis_out_if.source     o_out
);
    import rmis_pkg::*;

    // an 8-bit address reaches no further than 256 words
    localparam int DM_DEPTH = (DATA_DEPTH < 256) ? DATA_DEPTH : 256;
    localparam int PC_LIMIT = (INSTR_DEPTH < 256) ? INSTR_DEPTH : 256;
    localparam int CLR_N    = (REGS > DM_DEPTH) ? REGS : DM_DEPTH;
    localparam int RF_AW    = (REGS > 1) ? $clog2(REGS) : 1;
    localparam int DM_AW    = $clog2(DM_DEPTH);
    localparam int CW       = $clog2(CLR_N);

    // instruction latch
    logic [3:0]  r_op;
    logic [7:0]  r_a;
    logic [7:0]  r_b;
    logic [7:0]  r_c;
    logic [31:0] r_rv;

    // storage
    logic [31:0] r_rf [REGS];
    logic [31:0] r_dm [DM_DEPTH];
    logic [31:0] r_rf_q;
    logic [31:0] r_dm_q;
    logic [CW-1:0] r_clr_cnt;

    // operands and architectural state
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_prod;
    logic [7:0]  r_pc;
    logic [2:0]  r_stop;

    // result register
    logic        r_ov;
    logic [7:0]  r_o_pc;
    logic [2:0]  r_o_status;
    logic        r_o_emit;
    logic [31:0] r_o_value;

    logic        accept;
    logic        is_arith;
    logic [7:0]  addr1;
    logic [7:0]  addr2;
    logic        rok1;
    logic        rok2;
    logic [7:0]  rf_raddr;
    logic [31:0] y_op;
    logic [7:0]  dm_raddr;
    logic        dm_rok;
    logic [31:0] dm_rdata;

    logic        div_busy;
    logic [31:0] div_quo;

    logic        running;
    logic        y_zero;
    logic        jump;
    logic [7:0]  target;
    logic [8:0]  nxt;
    logic        trap;
    logic [2:0]  n_stop;
    logic [7:0]  n_pc;
    logic        rf_wen_op;
    logic [31:0] rf_wdata_op;
    logic        rf_we;
    logic [RF_AW-1:0] rf_waddr;
    logic [31:0] rf_wdata;
    logic        dm_we;
    logic [DM_AW-1:0] dm_waddr;
    logic [31:0] dm_wdata;
    logic        st_ok;
    logic        r_ok;
    logic        a_reg_ok;
    logic        emit;

    assign accept = i_in.valid & i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_in.opcode;
            r_a  <= i_in.operand_a;
            r_b  <= i_in.operand_b;
            r_c  <= i_in.operand_c;
            r_rv <= i_in.read_value;
        end
    end

    // register reads: first port slot gets reg[b] for arithmetic, else reg[a]
    always_comb begin
        case (r_op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: is_arith = 1'b1;
            default:                        is_arith = 1'b0;
        endcase
    end

    assign addr1    = is_arith ? r_b : r_a;
    assign addr2    = is_arith ? r_c : r_b;
    assign rok1     = 32'(addr1) < REGS;
    assign rok2     = 32'(addr2) < REGS;
    assign rf_raddr = i_cmd.rd1 ? addr1 : addr2;
    assign y_op     = rok2 ? r_rf_q : 32'd0;

    assign dm_raddr = (r_op == OP_W) ? r_a : r_b;
    assign dm_rok   = 32'(dm_raddr) < DM_DEPTH;
    assign dm_rdata = dm_rok ? r_dm_q : 32'd0;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd2) begin
            r_x <= rok1 ? r_rf_q : 32'd0;
        end
        if (i_cmd.exec) begin
            r_y    <= y_op;
            r_prod <= r_x * y_op;
        end
    end

    rmis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exec & o_sts.div_go),
        .i_num   (r_x),
        .i_den   (y_op),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // commit logic
    assign running = (r_stop == ST_RUN);
    assign y_zero  = (r_y == 32'd0);

    always_comb begin
        jump   = 1'b0;
        target = r_c;
        case (r_op)
            OP_JMP: begin
                jump   = 1'b1;
                target = r_a;
            end
            OP_JEQ: jump = (r_x == r_y);
            OP_JGT: jump = ~r_x[31] & (r_x != 32'd0);
            OP_JLT: jump = r_x[31];
            default: jump = 1'b0;
        endcase
    end

    assign nxt = jump ? {1'b0, target} : ({1'b0, r_pc} + 9'd1);

    always_comb begin
        trap = 1'b1;
        n_stop = r_stop;
        n_pc   = r_pc;
        if (running) begin
            if (r_op == OP_STP) begin
                n_stop = ST_HALT;
            end else if (r_op > OP_STP) begin
                n_stop = ST_BADOP;
            end else if ((r_op == OP_DIV) && y_zero) begin
                n_stop = ST_DIVZ;
            end else begin
                trap = 1'b0;
                // an overflowing pc still lets this instruction take effect
                if (32'(nxt) >= PC_LIMIT) begin
                    n_stop = ST_PCOVF;
                end else begin
                    n_pc = nxt[7:0];
                end
            end
        end
    end

    always_comb begin
        rf_wen_op   = 1'b1;
        rf_wdata_op = 32'd0;
        case (r_op)
            OP_ADD:  rf_wdata_op = r_x + r_y;
            OP_SUB:  rf_wdata_op = r_x - r_y;
            OP_MUL:  rf_wdata_op = r_prod;
            OP_DIV:  rf_wdata_op = div_quo;
            OP_MV:   rf_wdata_op = dm_rdata;
            default: rf_wen_op   = 1'b0;
        endcase
    end

    assign a_reg_ok = 32'(r_a) < REGS;
    assign rf_we    = i_cmd.clear ? (32'(r_clr_cnt) < REGS)
                                  : (i_cmd.fin & ~trap & rf_wen_op & a_reg_ok);
    assign rf_waddr = i_cmd.clear ? r_clr_cnt[RF_AW-1:0] : r_a[RF_AW-1:0];
    assign rf_wdata = i_cmd.clear ? 32'd0 : rf_wdata_op;

    assign st_ok    = (r_op == OP_ST) && (32'(r_b) < DM_DEPTH);
    assign r_ok     = (r_op == OP_R) && (32'(r_a) < DM_DEPTH);
    assign dm_we    = i_cmd.clear ? (32'(r_clr_cnt) < DM_DEPTH)
                                  : (i_cmd.fin & ~trap & (st_ok | r_ok));
    assign dm_waddr = i_cmd.clear ? r_clr_cnt[DM_AW-1:0]
                                  : (st_ok ? r_b[DM_AW-1:0] : r_a[DM_AW-1:0]);
    assign dm_wdata = (i_cmd.clear || !st_ok) ? (i_cmd.clear ? 32'd0 : r_rv) : r_x;

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        r_rf_q <= r_rf[rf_raddr[RF_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dm[dm_waddr] <= dm_wdata;
        end
        r_dm_q <= r_dm[dm_raddr[DM_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 8'd0;
            r_stop <= ST_RUN;
        end else if (i_cmd.fin) begin
            r_pc   <= n_pc;
            r_stop <= n_stop;
        end
    end

    // result register decouples the commit from the output transfer
    assign emit = running & (r_op == OP_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_pc     <= n_pc;
            r_o_status <= n_stop;
            r_o_emit   <= emit;
            r_o_value  <= emit ? dm_rdata : 32'd0;
        end
    end

    assign i_in.ready      = i_cmd.ready;
    assign o_out.valid     = r_ov;
    assign o_out.next_pc   = r_o_pc;
    assign o_out.status    = r_o_status;
    assign o_out.out_valid = r_o_emit;
    assign o_out.out_value = r_o_value;

    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_clr_cnt == CW'(CLR_N - 1));
        o_sts.in_valid = i_in.valid;
        o_sts.stopped  = ~running;
        o_sts.div_go   = (r_op == OP_DIV) && (y_op != 32'd0);
        o_sts.div_busy = div_busy;
        o_sts.out_free = ~r_ov | o_out.ready;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the register machine instruction step. Instructions
// go in over a valid/ready channel while a model in the bench tracks the
// registers, data memory, pc and stop code and predicts every step result.
// A directed set of corner cases runs first, then random programs under
// changing back-pressure, and last a stop that must stay sticky.
// ----------------------------------------------------------------------------
module tb;
    import rmis_pkg::*;

    localparam int REG_COUNT   = 16;
    localparam int NUM_WORDS   = 256;
    localparam int PC_LIMIT    = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [31:0] rv;
    } t_instr;

    typedef struct packed {
        logic [7:0]  next_pc;
        logic [2:0]  status;
        logic        out_valid;
        logic [31:0] out_value;
    } t_step;

    typedef enum int {END_HALT, END_BADOP, END_DIVZ, END_PCOVF} t_end_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmis_in_if  instr_if ();
    rmis_out_if step_if ();

    register_machine_instruction_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_if),
        .o_out   (step_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // architectural state as the bench sees it
    logic [31:0] arch_regs [REG_COUNT];
    logic [31:0] arch_mem  [NUM_WORDS];
    logic [7:0]  arch_pc;
    logic [2:0]  arch_stop;

    t_step pending_steps [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatches   = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_emitted    = 0;
    int n_divides    = 0;
    int n_jumps      = 0;
    int cycle_count  = 0;

    function automatic logic [31:0] reg_read(logic [7:0] idx);
        return (idx < REG_COUNT) ? arch_regs[idx] : 32'd0;
    endfunction

    function automatic void reg_write(logic [7:0] idx, logic [31:0] val);
        if (idx < REG_COUNT) arch_regs[idx] = val;
    endfunction

    function automatic logic [31:0] mem_read(logic [7:0] addr);
        return (addr < NUM_WORDS) ? arch_mem[addr] : 32'd0;
    endfunction

    function automatic void mem_write(logic [7:0] addr, logic [31:0] val);
        if (addr < NUM_WORDS) arch_mem[addr] = val;
    endfunction

    // truncating division on magnitudes, so the most negative value over -1 wraps
    function automatic logic [31:0] signed_quot(logic [31:0] n, logic [31:0] d);
        logic [31:0] mn;
        logic [31:0] md;
        logic [31:0] q;
        mn = n[31] ? 32'd0 - n : n;
        md = d[31] ? 32'd0 - d : d;
        q  = mn / md;
        return (n[31] ^ d[31]) ? 32'd0 - q : q;
    endfunction

    function automatic t_step execute_instr(t_instr ins);
        t_step       res;
        logic [8:0]  nxt;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] vc;
        res = '0;
        nxt = {1'b0, arch_pc} + 9'd1;
        if (arch_stop == ST_RUN) begin
            va = reg_read(ins.a);
            vb = reg_read(ins.b);
            vc = reg_read(ins.c);
            case (ins.opcode)
                OP_ADD: reg_write(ins.a, vb + vc);
                OP_SUB: reg_write(ins.a, vb - vc);
                OP_MUL: reg_write(ins.a, vb * vc);
                OP_DIV: begin
                    n_divides++;
                    if (vc == 32'd0) arch_stop = ST_DIVZ;
                    else reg_write(ins.a, signed_quot(vb, vc));
                end
                OP_MV:  reg_write(ins.a, mem_read(ins.b));
                OP_ST:  mem_write(ins.b, va);
                OP_JMP: nxt = {1'b0, ins.a};
                OP_JEQ: if (va == vb) nxt = {1'b0, ins.c};
                OP_JGT: if (!va[31] && va != 32'd0) nxt = {1'b0, ins.c};
                OP_JLT: if (va[31]) nxt = {1'b0, ins.c};
                OP_W: begin
                    res.out_valid = 1'b1;
                    res.out_value = mem_read(ins.a);
                end
                OP_R:   mem_write(ins.a, ins.rv);
                OP_STP: arch_stop = ST_HALT;
                default: arch_stop = ST_BADOP;
            endcase
            if (arch_stop == ST_RUN) begin
                if (nxt != {1'b0, arch_pc} + 9'd1) n_jumps++;
                if (nxt >= PC_LIMIT) arch_stop = ST_PCOVF;
                else arch_pc = nxt[7:0];
            end
        end
        res.next_pc = arch_pc;
        res.status  = arch_stop;
        return res;
    endfunction

    function automatic t_instr make_instr(logic [3:0] op, logic [7:0] a, logic [7:0] b,
                                          logic [7:0] c, logic [31:0] rv);
        t_instr ins;
        ins.opcode = op;
        ins.a      = a;
        ins.b      = b;
        ins.c      = c;
        ins.rv     = rv;
        return ins;
    endfunction

    // mostly real registers, now and then an index past the file
    function automatic logic [7:0] pick_reg();
        return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(REG_COUNT, 255))
                                           : 8'($urandom_range(0, REG_COUNT - 1));
    endfunction

    // keep most traffic on a few words so loads see stored data
    function automatic logic [7:0] pick_addr();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 31));
    endfunction

    // well-formed instruction that keeps the machine running
    function automatic t_instr random_instr();
        t_instr ins;
        int     pick;
        int     start;
        logic   found;
        ins = make_instr(4'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), $urandom);
        pick = $urandom_range(0, 99);
        if      (pick < 14) ins.opcode = OP_R;
        else if (pick < 26) ins.opcode = OP_MV;
        else if (pick < 34) ins.opcode = OP_ST;
        else if (pick < 42) ins.opcode = OP_W;
        else if (pick < 50) ins.opcode = OP_ADD;
        else if (pick < 58) ins.opcode = OP_SUB;
        else if (pick < 66) ins.opcode = OP_MUL;
        else if (pick < 76) ins.opcode = OP_DIV;
        else if (pick < 82) ins.opcode = OP_JMP;
        else if (pick < 88) ins.opcode = OP_JEQ;
        else if (pick < 94) ins.opcode = OP_JGT;
        else                ins.opcode = OP_JLT;
        case (ins.opcode)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                ins.a = pick_reg();
                ins.b = pick_reg();
                ins.c = pick_reg();
            end
            OP_MV, OP_ST: begin
                ins.a = pick_reg();
                ins.b = pick_addr();
            end
            OP_JEQ: begin
                ins.a = pick_reg();
                ins.b = pick_reg();
            end
            OP_JGT, OP_JLT: ins.a = pick_reg();
            OP_W, OP_R: ins.a = pick_addr();
            default: ;
        endcase
        if (ins.opcode == OP_DIV && reg_read(ins.c) == 32'd0) begin
            found = 1'b0;
            start = $urandom_range(0, REG_COUNT - 1);
            for (int k = 0; k < REG_COUNT; k++) begin
                if (!found && arch_regs[(start + k) % REG_COUNT] != 32'd0) begin
                    ins.c = 8'((start + k) % REG_COUNT);
                    found = 1'b1;
                end
            end
            if (!found) ins.opcode = OP_SUB;
        end
        // the last fetch address may only be left by a jump
        if (arch_pc == 8'hFF) ins.opcode = OP_JMP;
        return ins;
    endfunction

    task automatic send_instr(input t_instr ins);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            instr_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        instr_if.valid      <= 1'b1;
        instr_if.opcode     <= ins.opcode;
        instr_if.operand_a  <= ins.a;
        instr_if.operand_b  <= ins.b;
        instr_if.operand_c  <= ins.c;
        instr_if.read_value <= ins.rv;
        @(posedge i_clk);
        while (!instr_if.ready) @(posedge i_clk);
        pending_steps.push_back(execute_instr(ins));
        n_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        instr_if.valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_step want, input t_step got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch (%s) at result %0d: pc %0d/%0d status %0d/%0d",
                     what, n_checked, want.next_pc, got.next_pc, want.status, got.status);
            $display("    out_valid %0d/%0d out_value %h/%h (expected/actual)",
                     want.out_valid, got.out_valid, want.out_value, got.out_value);
        end
    endtask

    task automatic check_step();
        t_step want;
        t_step got;
        got = {step_if.next_pc, step_if.status, step_if.out_valid, step_if.out_value};
        if (got.out_valid) n_emitted++;
        if (pending_steps.size() == 0) begin
            note_mismatch("unexpected", '0, got);
        end else begin
            want = pending_steps.pop_front();
            if (got.next_pc != want.next_pc) note_mismatch("next_pc", want, got);
            else if (got.status != want.status) note_mismatch("status", want, got);
            else if (got.out_valid != want.out_valid) note_mismatch("out_valid", want, got);
            else if (got.out_value != want.out_value) note_mismatch("out_value", want, got);
        end
        n_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && step_if.valid && step_if.ready) check_step();
    end

    always @(negedge i_clk) begin
        step_if.ready <= i_rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_steps.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // overflowing arithmetic, the wrapping divide, jumps taken and not, far indexes
    task automatic test_arith_corners();
        send_instr(make_instr(OP_R,   8'd0,   8'd0,   8'd0,   32'h8000_0000));
        send_instr(make_instr(OP_R,   8'd1,   8'd0,   8'd0,   32'hFFFF_FFFF));
        send_instr(make_instr(OP_R,   8'd2,   8'd0,   8'd0,   32'h7FFF_FFFF));
        send_instr(make_instr(OP_R,   8'd255, 8'd255, 8'd255, $urandom));
        send_instr(make_instr(OP_MV,  8'd1,   8'd0,   8'd0,   32'd0));
        send_instr(make_instr(OP_MV,  8'd2,   8'd1,   8'd0,   32'd0));
        send_instr(make_instr(OP_MV,  8'd3,   8'd2,   8'd0,   32'd0));
        send_instr(make_instr(OP_DIV, 8'd4,   8'd1,   8'd2,   32'd0));
        send_instr(make_instr(OP_DIV, 8'd5,   8'd3,   8'd2,   32'd0));
        send_instr(make_instr(OP_DIV, 8'd6,   8'd2,   8'd3,   32'd0));
        send_instr(make_instr(OP_MUL, 8'd7,   8'd3,   8'd3,   32'd0));
        send_instr(make_instr(OP_ADD, 8'd8,   8'd3,   8'd3,   32'd0));
        send_instr(make_instr(OP_SUB, 8'd9,   8'd1,   8'd3,   32'd0));
        send_instr(make_instr(OP_ST,  8'd9,   8'd3,   8'd0,   32'd0));
        send_instr(make_instr(OP_W,   8'd3,   8'd0,   8'd0,   32'd0));
        send_instr(make_instr(OP_W,   8'd255, 8'd0,   8'd0,   32'd0));
        send_instr(make_instr(OP_JEQ, 8'd1,   8'd1,   8'd200, 32'd0));
        send_instr(make_instr(OP_JGT, 8'd3,   8'd0,   8'd100, 32'd0));
        send_instr(make_instr(OP_JLT, 8'd1,   8'd0,   8'd255, 32'd0));
        send_instr(make_instr(OP_JMP, 8'd0,   8'd0,   8'd0,   32'd0));
        send_instr(make_instr(OP_JGT, 8'd0,   8'd0,   8'd50,  32'd0));
        send_instr(make_instr(OP_JLT, 8'd3,   8'd0,   8'd50,  32'd0));
        send_instr(make_instr(OP_JEQ, 8'd1,   8'd3,   8'd50,  32'd0));
        send_instr(make_instr(OP_ADD, 8'd200, 8'd255, 8'd17,  32'd0));
        send_instr(make_instr(OP_MV,  8'd16,  8'd2,   8'd0,   32'd0));
    endtask

    task automatic test_random_program(input int n, input int src_pct, input int snk_pct);
        // let the machine drain fully before the new idling pattern starts
        wait_for_results();
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (n) send_instr(random_instr());
    endtask

    // one stop per run since reset comes only once; afterwards every step holds
    task automatic test_sticky_stop();
        t_end_kind kind;
        kind = t_end_kind'($urandom_range(0, 3));
        case (kind)
            END_HALT:  send_instr(make_instr(OP_STP, 8'd0, 8'd0, 8'd0, 32'd0));
            END_BADOP: send_instr(make_instr(4'(13 + $urandom_range(0, 2)), 8'd0, 8'd0,
                                             8'd0, 32'd0));
            END_DIVZ:  send_instr(make_instr(OP_DIV, pick_reg(), pick_reg(),
                                             8'($urandom_range(REG_COUNT, 255)), 32'd0));
            default: begin
                // a write-out at the last address still emits its word
                send_instr(make_instr(OP_JMP, 8'd255, 8'd0, 8'd0, 32'd0));
                send_instr(make_instr(OP_W, pick_addr(), 8'd0, 8'd0, 32'd0));
            end
        endcase
        repeat (10)
            send_instr(make_instr(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  $urandom));
    endtask

    initial begin
        i_rst_n             = 1'b0;
        instr_if.valid      = 1'b0;
        instr_if.opcode     = OP_ADD;
        instr_if.operand_a  = 8'd0;
        instr_if.operand_b  = 8'd0;
        instr_if.operand_c  = 8'd0;
        instr_if.read_value = 32'sd0;
        for (int k = 0; k < REG_COUNT; k++) arch_regs[k] = 32'd0;
        for (int k = 0; k < NUM_WORDS; k++) arch_mem[k] = 32'd0;
        arch_pc   = 8'd0;
        arch_stop = ST_RUN;
        src_idle_pct = 30;
        snk_idle_pct = 46;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_arith_corners();
        test_random_program(550, 30, 46);
        test_random_program(550, 46, 30);
        test_random_program(550, 0, 0);
        test_sticky_stop();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d instructions sent (%0d divides, %0d taken jumps), %0d results checked",
                 n_sent, n_divides, n_jumps, n_checked);
        $display("%0d words written out, machine ended with stop code %0d after %0d cycles",
                 n_emitted, arch_stop, cycle_count);
        if (mismatches == 0 && pending_steps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
